>>> src/assert_macros.svh
// Assertion helpers shared by the RTL. Each one checks at every rising clk
// edge and is held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the following cycle.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/spq_pkg.sv
package spq_pkg;

  localparam int unsigned DEF_QUEUE_DEPTH = 16;

  localparam int unsigned VAL_W   = 32;
  localparam int unsigned PRI_W   = 16;
  localparam int unsigned ST_W    = 2;
  localparam int unsigned COUNT_W = 5;

  // request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic signed [PRI_W-1:0] priority_v;
  } spq_entry_t;

  // broadcast to every cell for the current word
  typedef struct packed {
    logic       ins;
    logic       rem;
    spq_entry_t entry;
  } spq_op_t;

endpackage

>>> src/spq_if.sv
interface spq_req_if import spq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic signed [VAL_W-1:0] item_value;
  logic signed [PRI_W-1:0] item_priority;

  modport source (output valid, req_type, item_value, item_priority, input ready);
  modport sink   (input valid, req_type, item_value, item_priority, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] out_value;
  logic signed [PRI_W-1:0] out_priority;
  logic [ST_W-1:0]         status;
  logic [COUNT_W-1:0]      entry_count;
  logic                    queue_empty;

  modport source (output valid, out_value, out_priority, status, entry_count, queue_empty,
                  input ready);
  modport sink   (input valid, out_value, out_priority, status, entry_count, queue_empty,
                  output ready);
endinterface

>>> src/spq_cell.sv
module spq_cell import spq_pkg::*; (
  input  logic       clk,
  input  spq_op_t    op,
  input  logic       occ,          // slot holds a live entry
  input  logic       left_higher,  // left neighbor stays put on insert
  input  spq_entry_t left_entry,
  input  spq_entry_t right_entry,
  output spq_entry_t entry,
  output logic       higher
);

  spq_entry_t entry_r;
  spq_entry_t entry_nxt;

  assign higher = occ && (entry_r.priority_v > op.entry.priority_v);
  assign entry  = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (op.ins) begin
      if (higher) begin
        entry_nxt = entry_r;
      end else if (left_higher) begin
        entry_nxt = op.entry;
      end else begin
        entry_nxt = left_entry;
      end
    end else if (op.rem) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

>>> src/sorted_priority_queue.sv
// Sorted priority queue, QUEUE_DEPTH entries, highest priority at the head.
//
// in_req  : request words. req_type selects insert (item_value, item_priority)
//           or remove of the head entry. Taken when valid and ready are high.
// out_rsp : one response word per request: removed value and priority (zero
//           on insert or underflow), status (ok / overflow / underflow), the
//           entry count after the request and an empty flag.
//
// The store is a row of identical cells. On each request every cell compares
// its priority with the new one in parallel and either keeps its entry, takes
// the new one, or takes a neighbor's, so the whole row shifts together.
// Equal priorities land ahead of older entries (newest first).
//
// A response is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle, set by the cell update and the one-word
// output register. in_req.ready stays high while the output register is empty
// or being drained, so a stalled receiver holds back the requester only once a
// finished response is waiting.
// Reset (synchronous, rst_n low): count goes to zero and the output register
// empties; cell contents are left as they are and are never read until written.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  spq_req_if.sink   in_req,
  spq_rsp_if.source out_rsp
);

`include "assert_macros.svh"

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  logic accept;
  logic full;
  logic empty;
  spq_op_t op;

  spq_entry_t entries [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] higher;
  logic [QUEUE_DEPTH-1:0] occ;

  // output register
  logic                    out_valid_r;
  logic signed [VAL_W-1:0] out_value_r;
  logic signed [PRI_W-1:0] out_priority_r;
  logic [ST_W-1:0]         status_r;
  logic [COUNT_W-1:0]      entry_count_r;
  logic                    queue_empty_r;
  logic [ST_W-1:0]         status_nxt;
  logic [31:0]             count_ext;

  assign in_req.ready = !out_valid_r || out_rsp.ready;
  assign accept       = in_req.valid && in_req.ready;

  assign full  = (count_r == CW'(QUEUE_DEPTH));
  assign empty = (count_r == '0);

  assign op.ins              = accept && (in_req.req_type == REQ_INSERT) && !full;
  assign op.rem              = accept && (in_req.req_type == REQ_REMOVE) && !empty;
  assign op.entry.value      = in_req.item_value;
  assign op.entry.priority_v = in_req.item_priority;

  always_comb begin
    count_nxt = count_r;
    if (op.ins) begin
      count_nxt = count_r + CW'(1);
    end else if (op.rem) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    status_nxt = ST_OK;
    if (in_req.req_type == REQ_INSERT) begin
      if (full) begin
        status_nxt = ST_OVERFLOW;
      end
    end else if (empty) begin
      status_nxt = ST_UNDERFLOW;
    end
  end

  // entry_count carries only the low bits when the depth outgrows the field
  assign count_ext = 32'(count_nxt);

  // the cell row; slot 0 is the head
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    spq_entry_t left_e;
    spq_entry_t right_e;
    logic       left_hi;

    assign occ[i] = (count_r > CW'(i));

    if (i == 0) begin : g_head
      assign left_e  = op.entry;
      assign left_hi = 1'b1;
    end else begin : g_body
      assign left_e  = entries[i-1];
      assign left_hi = higher[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_e = op.entry;   // shifted into a slot that is no longer live
    end else begin : g_mid
      assign right_e = entries[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .op          (op),
      .occ         (occ[i]),
      .left_higher (left_hi),
      .left_entry  (left_e),
      .right_entry (right_e),
      .entry       (entries[i]),
      .higher      (higher[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_value_r    <= op.rem ? entries[0].value      : '0;
      out_priority_r <= op.rem ? entries[0].priority_v : '0;
      status_r       <= status_nxt;
      entry_count_r  <= count_ext[COUNT_W-1:0];
      queue_empty_r  <= (count_nxt == '0);
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.out_value    = out_value_r;
  assign out_rsp.out_priority = out_priority_r;
  assign out_rsp.status       = status_r;
  assign out_rsp.entry_count  = entry_count_r;
  assign out_rsp.queue_empty  = queue_empty_r;

  // checks
  `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(QUEUE_DEPTH), "count above depth")
  `SPQ_ASSERT_NEXT(a_full_holds, accept && full && (in_req.req_type == REQ_INSERT),
                   $stable(count_r), "rejected insert changed the count")
  `SPQ_ASSERT_NOW(a_head_order, occ[1],
                  entries[0].priority_v >= entries[1].priority_v, "head out of order")
  `SPQ_ASSERT_NOW(a_underflow_empty, out_valid_r && (status_r == ST_UNDERFLOW),
                  queue_empty_r && (out_value_r == '0), "underflow word not empty")

endmodule

>>> tb/tb_sorted_priority_queue.sv
`timescale 1ns / 1ps

// Self-checking bench for the sorted priority queue.
// A short directed table walks the corner cases (remove on empty, priority
// extremes, equal priorities, fill to full, insert when full, partial drain), then
// random blocks of requests with a changing insert/remove mix push the
// queue between empty and full. Every response word is checked against a
// local copy of the queue or the row's typed answer, oldest expectation first.
module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int DEPTH    = DEF_QUEUE_DEPTH;
  localparam int N_RANDOM = 1900;

  // one expected response word
  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic signed [PRI_W-1:0] prio;
    logic [ST_W-1:0]         status;
    logic [COUNT_W-1:0]      count;
    logic                    empty;
  } rsp_t;

  // one row of the directed table; typed rows carry their own answer
  typedef struct {
    logic                    req;
    logic signed [VAL_W-1:0] val;
    logic signed [PRI_W-1:0] pri;
    bit                      typed;
    rsp_t                    want;
  } step_t;

  localparam rsp_t NO_RSP = '{32'sd0, 16'sd0, ST_OK, 5'd0, 1'b0};

  // Directed part: 1 underflow, 16 inserts to full, 1 overflow, 7 removes.
  // Rows with a typed answer are the ones readable without working the queue.
  step_t directed_tbl [0:24] = '{
    // remove on an empty queue right after reset
    '{REQ_REMOVE, 32'sh1234_5678, 16'sh0042, 1'b1,
      '{32'sd0, 16'sd0, ST_UNDERFLOW, 5'd0, 1'b1}},
    // first insert: nothing returned, one entry held
    '{REQ_INSERT, 32'sh7FFF_FFFF, 16'sh7FFF, 1'b1,
      '{32'sd0, 16'sd0, ST_OK, 5'd1, 1'b0}},
    '{REQ_INSERT, 32'sh8000_0000, 16'sh8000, 1'b0, NO_RSP},
    '{REQ_INSERT, 32'sh0000_0000, 16'sh0000, 1'b0, NO_RSP},
    // same priority as the last one: must come out ahead of it
    '{REQ_INSERT, 32'shFFFF_FFFF, 16'sh0000, 1'b0, NO_RSP},
    '{REQ_INSERT, 32'sh5555_AAAA, 16'sh7FFF, 1'b0, NO_RSP},
    '{REQ_INSERT, 32'shAAAA_5555, 16'sh8000, 1'b0, NO_RSP},
    '{REQ_INSERT, 32'sh0000_0001, 16'sh0001, 1'b0, NO_RSP},
    '{REQ_INSERT, 32'sh0F0F_F0F0, 16'shFFFF, 1'b0, NO_RSP},
    '{REQ_INSERT, 32'shF0F0_0F0F, 16'sh1234, 1'b0, NO_RSP},
    '{REQ_INSERT, 32'sh3C3C_C3C3, 16'shEDCB, 1'b0, NO_RSP},
    '{REQ_INSERT, 32'shC3C3_3C3C, 16'sh0000, 1'b0, NO_RSP},
    '{REQ_INSERT, 32'sh0123_4567, 16'sh0000, 1'b0, NO_RSP},
    '{REQ_INSERT, 32'sh89AB_CDEF, 16'sh7FFE, 1'b0, NO_RSP},
    '{REQ_INSERT, 32'shFEDC_BA98, 16'sh8001, 1'b0, NO_RSP},
    '{REQ_INSERT, 32'sh7654_3210, 16'sh00FF, 1'b0, NO_RSP},
    '{REQ_INSERT, 32'sh6996_9669, 16'shFF00, 1'b0, NO_RSP},
    // queue is full now: rejected, count stays at depth
    '{REQ_INSERT, 32'shDEAD_BEEF, 16'sh7FFF, 1'b1,
      '{32'sd0, 16'sd0, ST_OVERFLOW, 5'd16, 1'b0}},
    '{REQ_REMOVE, 32'shFFFF_FFFF, 16'shFFFF, 1'b0, NO_RSP},
    '{REQ_REMOVE, 32'sh0000_0000, 16'sh0000, 1'b0, NO_RSP},
    '{REQ_REMOVE, 32'shA5A5_A5A5, 16'sh5A5A, 1'b0, NO_RSP},
    '{REQ_REMOVE, 32'sh5A5A_5A5A, 16'shA5A5, 1'b0, NO_RSP},
    '{REQ_REMOVE, 32'sh0000_0000, 16'sh0000, 1'b0, NO_RSP},
    '{REQ_REMOVE, 32'sh0000_0000, 16'sh0000, 1'b0, NO_RSP},
    '{REQ_REMOVE, 32'sh0000_0000, 16'sh0000, 1'b0, NO_RSP}
  };

  logic clk = 1'b0;
  logic rst_n;

  spq_req_if req_bus ();
  spq_rsp_if rsp_bus ();

  sorted_priority_queue #(.QUEUE_DEPTH(DEPTH)) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_bus),
    .out_rsp (rsp_bus)
  );

  always #4 clk = ~clk;

  // local copy of the queue, head at slot 0
  logic signed [VAL_W-1:0] held_val [DEPTH];
  logic signed [PRI_W-1:0] held_pri [DEPTH];
  int                      held_n;

  rsp_t pending_rsp [$];   // response words still owed by the block
  rsp_t want;
  int   fail_cnt;

  // idle control: "calm" stretches run with no gaps on that side
  bit tx_calm;
  bit rx_calm;
  int rx_stall;

  // coverage tallies, taken from the checked words
  int n_ovf, n_unf, n_full, n_empty;

  // Apply one request to the local queue and return the word it should give.
  function automatic rsp_t queue_apply(logic req, logic signed [VAL_W-1:0] v,
                                       logic signed [PRI_W-1:0] p);
    rsp_t r;
    int   pos;
    r = NO_RSP;
    if (req == REQ_INSERT) begin
      if (held_n >= DEPTH) begin
        r.status = ST_OVERFLOW;
      end else begin
        // stop at the first entry not above the new one: newest wins ties
        pos = 0;
        while (pos < held_n && held_pri[pos] > p) pos++;
        for (int i = held_n; i > pos; i--) begin
          held_val[i] = held_val[i-1];
          held_pri[i] = held_pri[i-1];
        end
        held_val[pos] = v;
        held_pri[pos] = p;
        held_n++;
      end
    end else begin
      if (held_n == 0) begin
        r.status = ST_UNDERFLOW;
      end else begin
        r.value = held_val[0];
        r.prio  = held_pri[0];
        for (int i = 1; i < held_n; i++) begin
          held_val[i-1] = held_val[i];
          held_pri[i-1] = held_pri[i];
        end
        held_n--;
      end
    end
    r.count = COUNT_W'(held_n);
    r.empty = (held_n == 0);
    return r;
  endfunction

  function automatic void check_field(string name, logic signed [63:0] expv,
                                      logic signed [63:0] actv);
    if (actv !== expv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      fail_cnt++;
    end
  endfunction

  // Drive one request word, hold it until taken, then book its expectation.
  // valid stays high on return so back-to-back words need no extra NBA.
  task automatic send_request(input logic req, input logic signed [VAL_W-1:0] v,
                              input logic signed [PRI_W-1:0] p, input bit typed,
                              input rsp_t typed_rsp);
    int   gap;
    rsp_t r;
    gap = tx_calm ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid         <= 1'b1;
    req_bus.req_type      <= req;
    req_bus.item_value    <= v;
    req_bus.item_priority <= p;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    r = queue_apply(req, v, p);
    pending_rsp.push_back(typed ? typed_rsp : r);
  endtask

  // Drop valid and wait for every owed word; always waits on the clock at least
  // once so a following send never lands a second NBA on valid in this step.
  task automatic hold_until_drained();
    int w;
    req_bus.valid <= 1'b0;
    w = 0;
    do begin
      @(posedge clk);
      w++;
    end while (pending_rsp.size() != 0 && w < 2000);
    if (pending_rsp.size() != 0) begin
      $error("%0d response words never arrived", pending_rsp.size());
      fail_cnt++;
      pending_rsp.delete();
    end
  endtask

  // Receiver: checks each accepted word, then draws a stall for the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_bus.ready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (pending_rsp.size() == 0) begin
          $error("response word with nothing expected");
          fail_cnt++;
        end else begin
          want = pending_rsp.pop_front();
          check_field("out_value",    want.value,  rsp_bus.out_value);
          check_field("out_priority", want.prio,   rsp_bus.out_priority);
          check_field("status",       want.status, rsp_bus.status);
          check_field("entry_count",  want.count,  rsp_bus.entry_count);
          check_field("queue_empty",  want.empty,  rsp_bus.queue_empty);
          case (want.status)
            ST_OVERFLOW:  n_ovf++;
            ST_UNDERFLOW: n_unf++;
            default: if (want.empty) n_empty++;
          endcase
          if (want.count == DEPTH) n_full++;
        end
        // flip between stalling and free-running now and then
        if ($urandom_range(0, 47) == 0) rx_calm = ~rx_calm;
        rx_stall = rx_calm ? 0 : $urandom_range(0, 12);
      end
      if (rx_stall != 0) begin
        rsp_bus.ready <= 1'b0;
        rx_stall--;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int                      sent, blk, blk_len, ins_pct, pri_mode;
    logic                    req;
    logic signed [VAL_W-1:0] v;
    logic signed [PRI_W-1:0] p;

    rst_n                 = 1'b0;
    req_bus.valid         = 1'b0;
    req_bus.req_type      = REQ_INSERT;
    req_bus.item_value    = '0;
    req_bus.item_priority = '0;
    held_n   = 0;
    fail_cnt = 0;
    tx_calm  = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_tbl[i])
      send_request(directed_tbl[i].req, directed_tbl[i].val, directed_tbl[i].pri,
                   directed_tbl[i].typed, directed_tbl[i].want);
    // sender stands back until the directed words are all in
    hold_until_drained();

    // Random blocks: each block picks an insert/remove mix, a priority style
    // and a sender idle style. Heavy-insert blocks reach overflow, heavy-remove
    // blocks reach underflow, the narrow priority styles make lots of ties.
    sent = 0;
    blk  = 0;
    while (sent < N_RANDOM) begin
      blk_len = $urandom_range(16, 64);
      case ($urandom_range(0, 4))
        0:       ins_pct = 5;
        1:       ins_pct = 30;
        2:       ins_pct = 50;
        3:       ins_pct = 70;
        default: ins_pct = 95;
      endcase
      pri_mode = $urandom_range(0, 2);
      tx_calm  = ($urandom_range(0, 3) == 0);
      if (blk % 9 == 8) hold_until_drained();
      for (int k = 0; k < blk_len && sent < N_RANDOM; k++) begin
        req = ($urandom_range(0, 99) < ins_pct) ? REQ_INSERT : REQ_REMOVE;
        v   = $urandom;
        case (pri_mode)
          0: p = PRI_W'($urandom);
          1: p = PRI_W'($urandom_range(0, 6) - 3);
          default: begin
            case ($urandom_range(0, 3))
              0:       p = 16'sh7FFF;
              1:       p = 16'sh8000;
              2:       p = 16'sh0000;
              default: p = 16'shFFFF;
            endcase
          end
        endcase
        send_request(req, v, p, 1'b0, NO_RSP);
        sent++;
      end
      blk++;
    end

    hold_until_drained();
    repeat (4) @(posedge clk);

    $display("Ran %0d directed and %0d random requests in %0d blocks.",
             $size(directed_tbl), sent, blk);
    $display("Seen: %0d overflows, %0d underflows, %0d words at full depth, %0d drains.",
             n_ovf, n_unf, n_full, n_empty);
    if (fail_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: stops the run as failed if it has not finished in time.
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
